// ----- hw/rtl/thc_pkg.sv -----
// Package for the two-level cache hit classifier: geometry defaults,
// status codes and the access and result beat types. No dependencies.
`default_nettype none
package thc_pkg;

  localparam int unsigned L1_BLOCK_BYTES_DEF = 64;
  localparam int unsigned L1_WAYS_DEF        = 4;
  localparam int unsigned L1_SETS_DEF        = 64;
  localparam int unsigned L2_BLOCK_BYTES_DEF = 64;
  localparam int unsigned L2_WAYS_DEF        = 8;
  localparam int unsigned L2_SETS_DEF        = 512;
  localparam int unsigned ADDR_BITS          = 32;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_RHIT  = 3'd1,
    ST_RMISS = 3'd2,
    ST_WHIT  = 3'd3,
    ST_WMISS = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } access_t;

  typedef struct packed {
    logic [2:0] l1_status;
    logic [2:0] l2_status;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic clear;
  } thc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
  } thc_sts_t;

  // floor(log2(v)), elaboration-time only
  function automatic int unsigned flog2(input int unsigned v);
    int unsigned n;
    n = 0;
    while (n < 31 && (64'd1 << (n + 1)) <= v) n++;
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/thc_level.sv -----
// One cache level: tag, valid and rank memories per set, with a
// hit/victim search and rank update. Uses thc_pkg.
`default_nettype none
module thc_level #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned SETS  = 64,
  parameter int unsigned BLOCK = 64
) (
  input  wire logic        clk,
  input  wire logic [31:0] address,
  input  wire logic        lookup,
  input  wire logic        update,
  input  wire logic        clear,
  input  wire logic        clr_wr,
  input  wire logic [$clog2(SETS+1)-1:0] clr_idx,
  output logic             hit
);
  import thc_pkg::*;

  localparam int unsigned OFFB = flog2(BLOCK);
  localparam int unsigned IDXB = flog2(SETS);
  localparam int unsigned SH   = OFFB + IDXB;
  localparam int unsigned TAGW = (SH >= ADDR_BITS) ? 1 : ADDR_BITS - SH;
  localparam int unsigned NSET = 1 << IDXB;
  localparam int unsigned AW   = (IDXB == 0) ? 1 : IDXB;
  localparam int unsigned RW   = (WAYS <= 1) ? 1 : $clog2(WAYS);
  localparam int unsigned WW   = (WAYS <= 1) ? 1 : $clog2(WAYS);

  typedef logic [WAYS-1:0][TAGW-1:0] tags_t;
  typedef logic [WAYS-1:0][RW-1:0]   ranks_t;

  // one row per set, read synchronously
  tags_t          tag_mem  [NSET];
  logic [WAYS-1:0] val_mem [NSET];
  ranks_t         rank_mem [NSET];

  tags_t           tag_row;
  logic [WAYS-1:0] val_row;
  ranks_t          rank_row;
  logic [AW-1:0]   set_q;

  logic [AW-1:0]   set_a;
  logic [TAGW-1:0] tag_a;

  always_comb begin
    set_a = (IDXB == 0) ? '0 : AW'(address >> OFFB);
    tag_a = (SH >= ADDR_BITS) ? '0 : TAGW'(address >> SH);
  end

  // hit and victim search over the row, and the updated rows for write-back
  logic [WW-1:0] hit_way, vic_way, way;
  logic          any_inv;
  logic [RW-1:0] rsel;
  ranks_t          rank_new;
  logic [WAYS-1:0] val_new;
  tags_t           tag_new;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (val_row[w] && tag_row[w] == tag_a) begin
        hit = 1'b1;
        hit_way = WW'(w);
      end
    end
    any_inv = 1'b0;
    vic_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!val_row[w]) begin
        any_inv = 1'b1;
        vic_way = WW'(w);
      end
    end
    if (!any_inv) begin
      for (int w = 1; w < WAYS; w++) begin
        if (rank_row[w] < rank_row[vic_way]) vic_way = WW'(w);
      end
    end
    way = hit ? hit_way : vic_way;
    rsel = rank_row[way];
    rank_new = rank_row;
    val_new = val_row;
    tag_new = tag_row;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) != way && rank_row[w] > rsel) rank_new[w] = rank_row[w] - 1'b1;
    end
    rank_new[way] = RW'(WAYS - 1);
    val_new[way] = 1'b1;
    tag_new[way] = tag_a;
  end

  // memory clear, read and write
  always_ff @(posedge clk) begin
    if (clear) begin
      if (clr_wr) begin
        val_mem[AW'(clr_idx)]  <= '0;
        rank_mem[AW'(clr_idx)] <= '0;
      end
    end else if (lookup) begin
      tag_row  <= tag_mem[set_a];
      val_row  <= val_mem[set_a];
      rank_row <= rank_mem[set_a];
      set_q    <= set_a;
    end else if (update) begin
      tag_mem[set_q]  <= tag_new;
      val_mem[set_q]  <= val_new;
      rank_mem[set_q] <= rank_new;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/thc_datapath.sv -----
// Datapath: access register, both levels, status decision and the
// clearing sweep counter. Uses thc_pkg and thc_level.
`default_nettype none
module thc_datapath #(
  parameter int unsigned L1_BLOCK_BYTES = thc_pkg::L1_BLOCK_BYTES_DEF,
  parameter int unsigned L1_WAYS        = thc_pkg::L1_WAYS_DEF,
  parameter int unsigned L1_SETS        = thc_pkg::L1_SETS_DEF,
  parameter int unsigned L2_BLOCK_BYTES = thc_pkg::L2_BLOCK_BYTES_DEF,
  parameter int unsigned L2_WAYS        = thc_pkg::L2_WAYS_DEF,
  parameter int unsigned L2_SETS        = thc_pkg::L2_SETS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire thc_pkg::access_t in_beat,
  input  wire thc_pkg::thc_cmd_t cmd,
  output thc_pkg::thc_sts_t     sts,
  output thc_pkg::result_t      res
);
  import thc_pkg::*;

  localparam int unsigned N1 = 1 << flog2(L1_SETS);
  localparam int unsigned N2 = 1 << flog2(L2_SETS);
  localparam int unsigned NC = (N1 > N2) ? N1 : N2;
  localparam int unsigned CW = $clog2(NC + 1);

  access_t acc;
  logic [CW-1:0] clr_cnt;
  logic h1, h2, up1, up2;

  always_ff @(posedge clk) begin
    if (cmd.load) acc <= in_beat;
  end

  // sweep counter for the post-reset clear
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear && clr_cnt != CW'(NC)) clr_cnt <= clr_cnt + 1'b1;
  end
  assign sts.clear_done = (clr_cnt == CW'(NC));

  thc_level #(.WAYS(L1_WAYS), .SETS(L1_SETS), .BLOCK(L1_BLOCK_BYTES)) u_l1 (
    .clk, .address(acc.address), .lookup(cmd.lookup), .update(up1),
    .clear(cmd.clear), .clr_wr(clr_cnt < CW'(N1)),
    .clr_idx($clog2(L1_SETS+1)'(clr_cnt)), .hit(h1)
  );
  thc_level #(.WAYS(L2_WAYS), .SETS(L2_SETS), .BLOCK(L2_BLOCK_BYTES)) u_l2 (
    .clk, .address(acc.address), .lookup(cmd.lookup), .update(up2),
    .clear(cmd.clear), .clr_wr(clr_cnt < CW'(N2)),
    .clr_idx($clog2(L2_SETS+1)'(clr_cnt)), .hit(h2)
  );

  // status and update decisions
  always_comb begin
    if (!acc.action) begin
      up1 = cmd.update;
      up2 = cmd.update && !h1;
      res.l1_status = h1 ? ST_RHIT : ST_RMISS;
      res.l2_status = h1 ? ST_NONE : (h2 ? ST_RHIT : ST_RMISS);
    end else begin
      up1 = cmd.update && h1;
      up2 = cmd.update && h2;
      res.l1_status = h1 ? ST_WHIT : ST_WMISS;
      res.l2_status = h2 ? ST_WHIT : (h1 ? ST_NONE : ST_WMISS);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/thc_ctrl.sv -----
// Controller: clear sweep, then load / lookup / update per beat, with
// an output register. Uses thc_pkg.
`default_nettype none
module thc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire thc_pkg::thc_sts_t sts,
  input  wire thc_pkg::result_t  res,
  output thc_pkg::result_t       out_beat,
  output thc_pkg::thc_cmd_t      cmd
);
  import thc_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_UPD} state_t;
  state_t state;

  logic take;
  // accept when idle and the output slot is free or leaving
  assign in_stall = !(state == S_IDLE && (!out_valid || !out_stall));
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.load   = take;
    cmd.lookup = (state == S_LOOK);
    cmd.update = (state == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: if (sts.clear_done) state <= S_IDLE;
        S_IDLE:  if (take) state <= S_LOOK;
        S_LOOK:  state <= S_UPD;
        S_UPD: begin
          out_beat  <= res;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/two_level_cache_hit_classifier.sv -----
// Two-level cache hit classifier. An accepted beat passes through load,
// set read and row write-back over the synchronous set memories; the
// result is registered, and no new beat is accepted until the block is back
// in idle. After reset a clearing pass over max(L1 sets, L2 sets) set
// indices clears valid and rank rows before the first beat is accepted.
`default_nettype none
module two_level_cache_hit_classifier #(
  parameter int unsigned L1_BLOCK_BYTES = thc_pkg::L1_BLOCK_BYTES_DEF,
  parameter int unsigned L1_WAYS        = thc_pkg::L1_WAYS_DEF,
  parameter int unsigned L1_SETS        = thc_pkg::L1_SETS_DEF,
  parameter int unsigned L2_BLOCK_BYTES = thc_pkg::L2_BLOCK_BYTES_DEF,
  parameter int unsigned L2_WAYS        = thc_pkg::L2_WAYS_DEF,
  parameter int unsigned L2_SETS        = thc_pkg::L2_SETS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire thc_pkg::access_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output thc_pkg::result_t      out_data
);
  import thc_pkg::*;

  thc_cmd_t cmd;
  thc_sts_t sts;
  result_t  res;

  thc_datapath #(
    .L1_BLOCK_BYTES(L1_BLOCK_BYTES), .L1_WAYS(L1_WAYS), .L1_SETS(L1_SETS),
    .L2_BLOCK_BYTES(L2_BLOCK_BYTES), .L2_WAYS(L2_WAYS), .L2_SETS(L2_SETS)
  ) u_dp (
    .clk, .rst, .in_beat(in_data), .cmd, .sts, .res
  );

  thc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .res, .out_beat(out_data), .cmd
  );
endmodule
`default_nettype wire

// ----- hw/rtl/thc_checker.sv -----
// Port-level checker for the classifier, bound to the top level.
// Uses thc_pkg.
`default_nettype none
module thc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire thc_pkg::result_t out_data
);
  import thc_pkg::*;

  // a result beat never appears right after an accept
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !($rose(out_valid)))
    else $error("result too early");

  // no accept in the cycle after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back accept");

  // L1 status is never no-action on a result
  a_l1: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.l1_status != ST_NONE))
    else $error("bad l1 status");

  // a read hit in L1 leaves L2 untouched
  a_l2: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.l1_status == ST_RHIT) |-> out_data.l2_status == ST_NONE)
    else $error("bad l2 status");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
endmodule

bind two_level_cache_hit_classifier thc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
